/* rtl/frame_time_outlier_smoother_unit_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef FRAME_TIME_OUTLIER_SMOOTHER_UNIT_DEFINES_SVH
`define FRAME_TIME_OUTLIER_SMOOTHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FTOS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ftos assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FTOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ftos assertion failed");

`endif

/* rtl/ftos_pkg.sv */
package ftos_pkg;

	localparam int unsigned TIME_W              = 16;
	localparam int unsigned R_W                 = 16;
	localparam int unsigned EXP_TABLE_DEPTH_DEF = 1024;
	localparam int unsigned QUIET_FRAMES_DEF    = 64;
	localparam logic [TIME_W-1:0] RESET_CAP_US  = 16'd33333;
	localparam logic [TIME_W-1:0] RESET_EST_US  = 16'd2000;
	localparam longint unsigned OFFSET_US       = 64'd4000;
	localparam longint unsigned DECAY_DIVISOR   = 64'd200000;
	localparam longint unsigned ONE_Q30         = 64'd1 << 30;

	// Retention factor exp(-(64*idx + 4000) / 200000) in Q0.16, from a Taylor
	// series of thirteen terms summed in Q2.30. It is evaluated only on constant indexes.
	function automatic logic [R_W-1:0] exp_entry(input int unsigned idx);
		longint unsigned x;
		longint unsigned sum;
		longint unsigned term;
		longint unsigned rnd;
		x    = ((64 * longint'(idx) + OFFSET_US) << 30) / DECAY_DIVISOR;
		term = (ONE_Q30 * x) >> 30;
		sum  = ONE_Q30 - term;
		term = ((term * x) >> 30) / 64'd2;
		sum  = sum + term;
		term = ((term * x) >> 30) / 64'd3;
		sum  = sum - term;
		term = ((term * x) >> 30) / 64'd4;
		sum  = sum + term;
		term = ((term * x) >> 30) / 64'd5;
		sum  = sum - term;
		term = ((term * x) >> 30) / 64'd6;
		sum  = sum + term;
		term = ((term * x) >> 30) / 64'd7;
		sum  = sum - term;
		term = ((term * x) >> 30) / 64'd8;
		sum  = sum + term;
		term = ((term * x) >> 30) / 64'd9;
		sum  = sum - term;
		term = ((term * x) >> 30) / 64'd10;
		sum  = sum + term;
		term = ((term * x) >> 30) / 64'd11;
		sum  = sum - term;
		term = ((term * x) >> 30) / 64'd12;
		sum  = sum + term;
		rnd  = (sum + (64'd1 << 13)) >> 14;
		return rnd[R_W-1:0];
	endfunction

endpackage

/* rtl/frame_time_outlier_smoother_unit.sv */
// Frame time smoother: each transfer on the input stream is one measured frame time in
// microseconds, and each produces one transfer on the output stream carrying the smoothed
// estimate and two flags. The block takes one frame time per clock cycle while the output is
// not stalled. The input register captures each sample together with its retention factor
// read from the ROM, and the estimate and the quiet frame counter are then updated from it
// as the result moves into the output register. A stalled output holds one result in the
// output register and one sample in the input register before the input is held off. The
// cap register may be written at any time the stream is idle and holds 33333 after reset.
module frame_time_outlier_smoother_unit #(
	parameter int unsigned EXP_TABLE_DEPTH     = ftos_pkg::EXP_TABLE_DEPTH_DEF,
	parameter int unsigned QUIET_FRAMES_NEEDED = ftos_pkg::QUIET_FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] frame_time_us
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] smoothed_time_us
	output logic [1:0]  m_tuser,   // [0] was_discarded, [1] was_capped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // [15:0] cap_time_us
);

	localparam int unsigned ADDR_W = $clog2(EXP_TABLE_DEPTH);
	localparam int unsigned CNT_W  = $clog2(QUIET_FRAMES_NEEDED + 1);
	localparam int unsigned TW     = ftos_pkg::TIME_W;
	localparam int unsigned RW     = ftos_pkg::R_W;

	logic [RW-1:0] rom [EXP_TABLE_DEPTH];

	for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
		assign rom[i] = ftos_pkg::exp_entry(i);
	end

	logic [TW-1:0]    cap_q;
	logic [TW-1:0]    est_q;
	logic [CNT_W-1:0] quiet_q;

	logic             valid_s1;
	logic [TW-1:0]    t_raw_s1;
	logic [TW-1:0]    t_flt_s1;
	logic             below_s1;
	logic [RW-1:0]    r_s1;

	logic             out_valid_q;
	logic [TW-1:0]    out_est_q;
	logic             out_disc_q;
	logic             out_cap_q;

	logic             in_xfer;
	logic             out_free;
	logic             adv_s1;
	logic             below_in;
	logic [TW-1:0]    t_flt_in;
	logic [31:0]      idx_wide;
	logic [31:0]      idx_lim;
	logic [ADDR_W-1:0] rom_addr;

	logic             quiet_enough;
	logic             discard;
	logic [TW:0]      twice_est;
	logic [RW:0]      r_comp;
	logic [32:0]      acc;
	logic [TW-1:0]    est_new;
	logic [CNT_W-1:0] quiet_new;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign adv_s1    = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign in_xfer   = s_tvalid && s_tready;

	assign below_in = s_tdata < cap_q;
	assign t_flt_in = below_in ? s_tdata : cap_q;
	assign idx_wide = {22'd0, t_flt_in[TW-1:6]};
	assign idx_lim  = (idx_wide >= 32'(EXP_TABLE_DEPTH)) ? 32'(EXP_TABLE_DEPTH - 1) : idx_wide;
	assign rom_addr = idx_lim[ADDR_W-1:0];

	assign quiet_enough = quiet_q >= CNT_W'(QUIET_FRAMES_NEEDED);
	assign twice_est    = {est_q, 1'b0};
	assign discard      = !below_s1 && quiet_enough && ({1'b0, t_raw_s1} > twice_est);
	assign r_comp       = 17'h10000 - {1'b0, r_s1};
	assign acc          = 33'(est_q) * 33'(r_s1) + 33'(t_flt_s1) * 33'(r_comp) + 33'd32768;
	assign est_new      = discard ? est_q : acc[31:16];

	always_comb begin
		if (!below_s1) begin
			quiet_new = '0;
		end else if (quiet_q < CNT_W'(QUIET_FRAMES_NEEDED)) begin
			quiet_new = quiet_q + CNT_W'(1);
		end else begin
			quiet_new = quiet_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= ftos_pkg::RESET_CAP_US;
			est_q       <= ftos_pkg::RESET_EST_US;
			quiet_q     <= CNT_W'(QUIET_FRAMES_NEEDED);
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				est_q   <= est_new;
				quiet_q <= quiet_new;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			t_raw_s1 <= s_tdata;
			t_flt_s1 <= t_flt_in;
			below_s1 <= below_in;
			r_s1     <= rom[rom_addr];
		end
		if (adv_s1) begin
			out_est_q  <= est_new;
			out_disc_q <= discard;
			out_cap_q  <= !below_s1 && !discard;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_est_q;
	assign m_tuser  = {out_cap_q, out_disc_q};

endmodule

/* rtl/ftos_checker.sv */
`include "frame_time_outlier_smoother_unit_defines.svh"

module ftos_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [15:0] cfg_data
);

	// A stalled result keeps its contents until the transfer completes.
	`FTOS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A discarded sample is never also reported as clamped.
	`FTOS_ASSERT_IMPL(a_flags_excl, clk, arst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))

	// With the output register empty, the input side is always open.
	`FTOS_ASSERT_IMPL(a_in_open, clk, arst_n, !m_tvalid, s_tready)

	// Cap writes are never held off.
	`FTOS_ASSERT_IMPL(a_cfg_taken, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind frame_time_outlier_smoother_unit ftos_checker u_ftos_checker (.*);
